// ----- design/chsf_pkg.sv -----
package chsf_pkg;

  localparam int unsigned CHANNELS_DEF = 16;

  localparam int unsigned CH_W      = 4;
  localparam int unsigned RANGE_W   = 48;
  localparam int unsigned WL_W      = 24;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ENTRY_W   = 2 * RANGE_W;

  localparam int unsigned MUL_A_W  = 27;
  localparam int unsigned MUL_B_W  = 30;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned K_W      = WL_W + MUL_B_W;
  localparam int unsigned HALF_W   = RANGE_W / 2;
  localparam int unsigned ACC_W    = K_W + RANGE_W;
  localparam int unsigned ADV_SHIFT = 56;
  localparam int unsigned ADV_W    = ACC_W - ADV_SHIFT;
  localparam int unsigned SUM_W    = RANGE_W + 1;
  localparam int unsigned HPROD_W  = RANGE_W + LEN_W;
  localparam int unsigned N_W      = HPROD_W + 3;
  localparam int unsigned SHIFT_W  = 6;

  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_STEPS = 4;

  localparam logic [MUL_B_W-1:0] INV2PI    = 30'd683565276;
  localparam logic [LEN_W-1:0]   LEN_RESET = 11'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd1;

  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic                      range_valid;
    logic signed [RANGE_W-1:0] raw_range;
    logic signed [RANGE_W-1:0] carrier_phase;
    logic [WL_W-1:0]           wavelength;
  } chsf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]           channel_out;
    logic                      range_valid_out;
    logic signed [RANGE_W-1:0] smoothed_range;
  } chsf_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_KCAP,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_ACCL,
    S_RND,
    S_SUM,
    S_SMAG,
    S_H0,
    S_H1,
    S_HACC,
    S_NSUM,
    S_NMAG,
    S_DIV,
    S_WB,
    S_DONE
  } chsf_state_e;

endpackage

// ----- design/chsf_stream_if.sv -----
interface chsf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );
endinterface

// ----- design/chsf_ram.sv -----
module chsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/chsf_div.sv -----
module chsf_div
  import chsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned ITER  = DIV_W / DIV_STEPS;
  localparam int unsigned CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [LEN_W-1:0] divisor_q;
  logic [LEN_W:0]   rem_step;
  logic [DIV_W-1:0] quo_step;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    rem_step = rem_q;
    quo_step = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_step = {rem_step[LEN_W-1:0], quo_step[DIV_W-1]};
      quo_step = {quo_step[DIV_W-2:0], 1'b0};
      if (rem_step >= {1'b0, divisor_q}) begin
        rem_step    = rem_step - {1'b0, divisor_q};
        quo_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ITER - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = rem_step;
      quo_d = quo_step;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/carrier_smoothing_filter.sv -----
// Items are handled one at a time: a new input is accepted only in the idle state, once the
// previous item has been loaded into the output register. A smoothed item uses the shared
// 27x30 multiplier (seven products) and the iterative divider by the filter length; an item
// that passes through goes straight to the output stage. Reset clears the lock flags, the
// enable and the control state and sets the length to 200; datapath registers and the state
// memory have no reset, since an entry is only used after its lock flag was set by a write.
module carrier_smoothing_filter
  import chsf_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i,
  chsf_stream_if.sink          in_i,
  chsf_stream_if.source        out_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chsf_state_e state_q, state_d;

  logic                  out_valid_q, out_valid_d;
  chsf_out_t             out_q;
  logic [CHANNELS-1:0]   locked_q;
  logic [LEN_W-1:0]      len_q;
  logic                  en_q;
  logic                  pend_q, pend_d;
  logic [SHIFT_W-1:0]    pshift_q, pshift_d;

  chsf_in_t              item_q;
  logic [RANGE_W-1:0]    res_q;
  logic [RANGE_W-1:0]    last_q;
  logic                  dneg_q;
  logic [RANGE_W-1:0]    dmag_q;
  logic [K_W-1:0]        k_q;
  logic [PROD_W-1:0]     prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [ADV_W-1:0]      advm_q;
  logic [SUM_W-1:0]      sum_q;
  logic                  sneg_q;
  logic [RANGE_W-1:0]    smag_q;
  logic [N_W-1:0]        nsum_q;
  logic                  nneg_q;

  logic                  in_accept;
  logic [AW-1:0]         in_addr;
  logic                  in_range;
  logic                  in_locked;
  logic                  smooth_go;
  logic                  seed_go;
  logic [LEN_W-1:0]      m_len;
  logic [LEN_W-1:0]      m_minus1;

  logic                  in_ready;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     mul_out;
  logic                  div_start;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;
  logic [DIV_W-1:0]      dividend;
  logic                  load_out;

  logic [SUM_W-1:0]      diff;
  logic [ACC_W-1:0]      rnd;
  logic [SUM_W-1:0]      adv_ext;
  logic [N_W-1:0]        hprod_ext;
  logic [N_W-1:0]        raw_ext;
  logic [N_W-1:0]        nmag;
  logic [RANGE_W-1:0]    sat_res;

  assign in_accept = in_i.valid && in_ready;
  assign in_addr   = AW'(in_i.data.channel);
  assign in_range  = 32'(in_i.data.channel) < CHANNELS;
  assign in_locked = in_range && locked_q[in_addr];
  assign smooth_go = en_q && in_range && in_i.data.range_valid && in_locked;
  assign seed_go   = en_q && in_range && in_i.data.range_valid && !in_locked;

  assign m_len    = (len_q == '0) ? LEN_W'(1) : len_q;
  assign m_minus1 = m_len - 1'b1;

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  chsf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  chsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (m_len),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = smooth_go ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: state_d = S_KCAP;
      S_KCAP: state_d = S_P0;
      S_P0:   state_d = S_P1;
      S_P1:   state_d = S_P2;
      S_P2:   state_d = S_P3;
      S_P3:   state_d = S_ACCL;
      S_ACCL: state_d = S_RND;
      S_RND:  state_d = S_SUM;
      S_SUM:  state_d = S_SMAG;
      S_SMAG: state_d = S_H0;
      S_H0:   state_d = S_H1;
      S_H1:   state_d = S_HACC;
      S_HACC: state_d = S_NSUM;
      S_NSUM: state_d = S_NMAG;
      S_NMAG: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_WB;
        end
      end
      S_WB:   state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(item_q.channel);
    ram_wdata = {res_q, item_q.carrier_phase};
    mul_a     = '0;
    mul_b     = '0;
    pend_d    = 1'b0;
    pshift_d  = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_we    = in_i.valid && seed_go;
        ram_waddr = in_addr;
        ram_wdata = {in_i.data.raw_range, in_i.data.carrier_phase};
      end
      S_LOAD: begin
        mul_a = MUL_A_W'(item_q.wavelength);
        mul_b = INV2PI;
      end
      S_P0: begin
        mul_a    = k_q[MUL_A_W-1:0];
        mul_b    = MUL_B_W'(dmag_q[HALF_W-1:0]);
        pend_d   = 1'b1;
        pshift_d = '0;
      end
      S_P1: begin
        mul_a    = k_q[MUL_A_W-1:0];
        mul_b    = MUL_B_W'(dmag_q[RANGE_W-1:HALF_W]);
        pend_d   = 1'b1;
        pshift_d = SHIFT_W'(HALF_W);
      end
      S_P2: begin
        mul_a    = k_q[K_W-1:MUL_A_W];
        mul_b    = MUL_B_W'(dmag_q[HALF_W-1:0]);
        pend_d   = 1'b1;
        pshift_d = SHIFT_W'(MUL_A_W);
      end
      S_P3: begin
        mul_a    = k_q[K_W-1:MUL_A_W];
        mul_b    = MUL_B_W'(dmag_q[RANGE_W-1:HALF_W]);
        pend_d   = 1'b1;
        pshift_d = SHIFT_W'(MUL_A_W + HALF_W);
      end
      S_H0: begin
        mul_a    = MUL_A_W'(smag_q[HALF_W-1:0]);
        mul_b    = MUL_B_W'(m_minus1);
        pend_d   = 1'b1;
        pshift_d = '0;
      end
      S_H1: begin
        mul_a    = MUL_A_W'(smag_q[RANGE_W-1:HALF_W]);
        mul_b    = MUL_B_W'(m_minus1);
        pend_d   = 1'b1;
        pshift_d = SHIFT_W'(HALF_W);
      end
      S_NMAG: div_start = 1'b1;
      S_WB:   ram_we    = 1'b1;
      S_DONE: load_out  = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign diff    = {item_q.carrier_phase[RANGE_W-1], item_q.carrier_phase}
                 - {ram_rdata[RANGE_W-1], ram_rdata[RANGE_W-1:0]};
  assign rnd     = acc_q + (ACC_W'(1) << (ADV_SHIFT - 1));
  assign adv_ext = SUM_W'(advm_q);
  assign hprod_ext = N_W'(acc_q[HPROD_W-1:0]);
  assign raw_ext = {{(N_W - RANGE_W){item_q.raw_range[RANGE_W-1]}}, item_q.raw_range};
  assign nmag    = nsum_q[N_W-1] ? (~nsum_q + 1'b1) : nsum_q;
  assign dividend = DIV_W'(nmag) + DIV_W'(m_len >> 1);

  // Round-half-away quotient, saturated to the 48-bit signed range.
  always_comb begin
    if (!nneg_q) begin
      if (div_quo[DIV_W-1:RANGE_W-1] != '0) begin
        sat_res = {1'b0, {(RANGE_W-1){1'b1}}};
      end else begin
        sat_res = div_quo[RANGE_W-1:0];
      end
    end else begin
      if (div_quo[DIV_W-1:RANGE_W] != '0
          || (div_quo[RANGE_W-1] && div_quo[RANGE_W-2:0] != '0)) begin
        sat_res = {1'b1, {(RANGE_W-1){1'b0}}};
      end else begin
        sat_res = ~div_quo[RANGE_W-1:0] + 1'b1;
      end
    end
  end

  assign out_valid_d = (out_valid_q && !out_o.ready) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      locked_q    <= '0;
      len_q       <= LEN_RESET;
      en_q        <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (in_accept && en_q && in_range) begin
        locked_q[in_addr] <= in_i.data.range_valid;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LENGTH: len_q <= cfg_wdata_i;
          CFG_ENABLE: en_q  <= cfg_wdata_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= mul_out;
    pshift_q <= pshift_d;
    if (pend_q) begin
      acc_q <= acc_q + (ACC_W'(prod_q) << pshift_q);
    end
    if (in_accept) begin
      item_q <= in_i.data;
      res_q  <= in_i.data.raw_range;
    end
    case (state_q)
      S_LOAD: begin
        last_q <= ram_rdata[ENTRY_W-1:RANGE_W];
        dneg_q <= diff[SUM_W-1];
        dmag_q <= diff[SUM_W-1] ? RANGE_W'(~diff + 1'b1) : diff[RANGE_W-1:0];
      end
      S_KCAP: begin
        k_q   <= prod_q[K_W-1:0];
        acc_q <= '0;
      end
      S_RND: advm_q <= rnd[ACC_W-1:ADV_SHIFT];
      S_SUM: begin
        sum_q <= {last_q[RANGE_W-1], last_q} + (dneg_q ? (~adv_ext + 1'b1) : adv_ext);
      end
      S_SMAG: begin
        sneg_q <= sum_q[SUM_W-1];
        smag_q <= sum_q[SUM_W-1] ? RANGE_W'(~sum_q + 1'b1) : sum_q[RANGE_W-1:0];
        acc_q  <= '0;
      end
      S_NSUM: nsum_q <= (sneg_q ? (~hprod_ext + 1'b1) : hprod_ext) + raw_ext;
      S_NMAG: nneg_q <= nsum_q[N_W-1];
      S_DIV: begin
        if (div_done) begin
          res_q <= sat_res;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_q.channel_out     <= item_q.channel;
      out_q.range_valid_out <= item_q.range_valid;
      out_q.smoothed_range  <= res_q;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
